// ===== sv/u8d_pkg.sv =====
package u8d_pkg;

    localparam int BYTE_W        = 8;
    localparam int CP_W          = 31;
    localparam int CNT_W         = 16;
    localparam int LEN_W         = 3;
    localparam int LEAD_BITS_W   = 7;
    localparam int CONT_BITS_W   = 6;
    localparam int MAX_CHARS_DEF = 65535;
    localparam int CNT_MAX       = (1 << CNT_W) - 1;

    localparam logic [BYTE_W-1:0] BOM_BYTE0 = 8'hEF;
    localparam logic [BYTE_W-1:0] BOM_BYTE1 = 8'hBB;
    localparam logic [BYTE_W-1:0] BOM_BYTE2 = 8'hBF;
    localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;

    localparam logic [LEN_W-1:0] BOM_POS1 = 3'd1;
    localparam logic [LEN_W-1:0] BOM_POS2 = 3'd2;

    typedef struct packed {
        logic                   bad;
        logic [LEN_W-1:0]       len;
        logic [LEAD_BITS_W-1:0] bits;
    } lead_info_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             bad_lead;
        logic             string_end;
        logic [CNT_W-1:0] char_count;
    } result_t;

endpackage

// ===== sv/u8d_lead_dec.sv =====
module u8d_lead_dec (
    input  logic [u8d_pkg::BYTE_W-1:0] lead_byte,
    output u8d_pkg::lead_info_t         info
);
    import u8d_pkg::*;

    always_comb begin
        info = '0;
        if (lead_byte inside {[8'h80:8'hBF], 8'hFE, 8'hFF}) begin
            info.bad = 1'b1;
        end else if ((lead_byte & 8'h80) == 8'h00) begin
            info.len  = 3'd1;
            info.bits = lead_byte[6:0];
        end else if ((lead_byte & 8'hE0) == 8'hC0) begin
            info.len  = 3'd2;
            info.bits = {2'b00, lead_byte[4:0]};
        end else if ((lead_byte & 8'hF0) == 8'hE0) begin
            info.len  = 3'd3;
            info.bits = {3'b000, lead_byte[3:0]};
        end else if ((lead_byte & 8'hF8) == 8'hF0) begin
            info.len  = 3'd4;
            info.bits = {4'b0000, lead_byte[2:0]};
        end else if ((lead_byte & 8'hFC) == 8'hF8) begin
            info.len  = 3'd5;
            info.bits = {5'b00000, lead_byte[1:0]};
        end else begin
            info.len  = 3'd6;
            info.bits = {6'b000000, lead_byte[0]};
        end
    end

endmodule

// ===== sv/u8d_core.sv =====
module u8d_core #(
    parameter int MAX_CHARS = u8d_pkg::MAX_CHARS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [u8d_pkg::BYTE_W-1:0] data_byte,
    output logic                       res_valid,
    output u8d_pkg::result_t           res
);
    import u8d_pkg::*;

    localparam int CAP_INT = (MAX_CHARS > CNT_MAX) ? CNT_MAX : MAX_CHARS;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    logic [CP_W-1:0]  code_accum_reg, code_accum_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0] seq_length_reg, seq_length_next;
    logic             at_start_reg, at_start_next;
    logic [CNT_W-1:0] chars_seen_reg, chars_seen_next;
    logic             bom_match_reg, bom_match_next;

    lead_info_t       lead;
    logic [LEN_W-1:0] pos;
    logic [CNT_W-1:0] chars_inc;

    u8d_lead_dec u_lead_dec (
        .lead_byte (data_byte),
        .info      (lead)
    );

    assign pos       = seq_length_reg - bytes_left_reg;
    assign chars_inc = (chars_seen_reg < COUNT_CAP) ? chars_seen_reg + 1'b1 : chars_seen_reg;

    always_comb begin
        code_accum_next = code_accum_reg;
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        at_start_next   = at_start_reg;
        chars_seen_next = chars_seen_reg;
        bom_match_next  = bom_match_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (bytes_left_reg != '0) begin
            if ((pos == BOM_POS1 && data_byte != BOM_BYTE1) ||
                (pos == BOM_POS2 && data_byte != BOM_BYTE2)) begin
                bom_match_next = 1'b0;
            end
            code_accum_next = {code_accum_reg[CP_W-CONT_BITS_W-1:0],
                               data_byte[CONT_BITS_W-1:0]};
            bytes_left_next = bytes_left_reg - 1'b1;
            if (bytes_left_next == '0) begin
                if (bom_match_next) begin
                    bom_match_next = 1'b0;
                end else begin
                    chars_seen_next = chars_inc;
                    res_valid       = 1'b1;
                    res.code_point  = code_accum_next;
                end
            end
        end else if (data_byte == NUL_BYTE) begin
            res_valid       = 1'b1;
            res.string_end  = 1'b1;
            res.char_count  = chars_seen_reg;
            chars_seen_next = '0;
            at_start_next   = 1'b1;
            bom_match_next  = 1'b0;
        end else begin
            at_start_next  = 1'b0;
            bom_match_next = 1'b0;
            if (lead.bad) begin
                code_accum_next = '0;
                seq_length_next = '0;
                chars_seen_next = chars_inc;
                res_valid       = 1'b1;
                res.bad_lead    = 1'b1;
            end else begin
                code_accum_next = CP_W'(lead.bits);
                seq_length_next = lead.len;
                if (lead.len == 3'd1) begin
                    chars_seen_next = chars_inc;
                    res_valid       = 1'b1;
                    res.code_point  = CP_W'(lead.bits);
                end else begin
                    bytes_left_next = lead.len - 1'b1;
                    bom_match_next  = at_start_reg && (data_byte == BOM_BYTE0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_accum_reg <= '0;
            bytes_left_reg <= '0;
            seq_length_reg <= '0;
            at_start_reg   <= 1'b1;
            chars_seen_reg <= '0;
            bom_match_reg  <= 1'b0;
        end else if (step) begin
            code_accum_reg <= code_accum_next;
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            at_start_reg   <= at_start_next;
            chars_seen_reg <= chars_seen_next;
            bom_match_reg  <= bom_match_next;
        end
    end

endmodule

// ===== sv/utf8_stream_decoder_unit.sv =====
// utf8 stream decoder
// input channel s_*: one raw byte of a stream of zero-terminated utf-8 strings per word
// result channel m_*: one decoded code point per completed sequence; a bad lead byte
// gives code point 0 with m_tuser set; a zero lead byte gives a word with m_tlast set
// that carries the saturating character count of the finished string
// a byte order mark ef bb bf at the start of a string gives no word
// an accepted byte is held in the input register and decoded from it into the output
// register, which drives m_*; throughput is one byte per cycle while the output register
// is empty or m_tready is high, set by the single decode step between the two registers
// continuation bytes and a dropped mark give no word but still take a decode step each
// when m_tready is low the output word holds, the input register fills, and s_tready
// falls only once both are occupied; no word is lost or repeated
// reset clears the valid flags of both registers and the decode state, so the next byte starts a new string
module utf8_stream_decoder_unit #(
    parameter int MAX_CHARS = u8d_pkg::MAX_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // code_point[30:0], char_count[46:31], zero[47]
    output logic        m_tuser,   // bad_lead
    output logic        m_tlast    // string_end
);
    import u8d_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;
    logic              out_free;
    logic              step;
    logic              res_valid;
    result_t           res;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    u8d_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (step && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.char_count, out_res_reg.code_point};
    assign m_tuser  = out_res_reg.bad_lead;
    assign m_tlast  = out_res_reg.string_end;

endmodule

// ===== dv/tb_utf8_stream_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_unit;
    import u8d_pkg::*;

    localparam int MAX_CHARS_TB = MAX_CHARS_DEF;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_BYTES = 1500;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_HALF,
        READY_SPARSE
    } ready_mode_e;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    utf8_stream_decoder_unit #(
        .MAX_CHARS(MAX_CHARS_TB)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    class decode_scoreboard;
        logic [CP_W-1:0]  accum;
        logic [LEN_W-1:0] left;
        logic [LEN_W-1:0] seq_len;
        bit               at_start;
        bit               mark_live;
        logic [CNT_W-1:0] chars;
        result_t          expected_words[$];
        int               errors;
        int               n_words;
        int               n_ends;
        int               n_bad;
        int               n_marks;
        int               n_capped;

        function new();
            accum     = '0;
            left      = '0;
            seq_len   = '0;
            at_start  = 1'b1;
            mark_live = 1'b0;
            chars     = '0;
            errors    = 0;
            n_words   = 0;
            n_ends    = 0;
            n_bad     = 0;
            n_marks   = 0;
            n_capped  = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void queue_word(result_t w);
            expected_words = {expected_words, w};
        endfunction

        function void count_char();
            int cap;
            cap = (MAX_CHARS_TB > CNT_MAX) ? CNT_MAX : MAX_CHARS_TB;
            if (chars < cap)
                chars++;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t          w;
            logic [LEN_W-1:0] pos;
            logic [LEN_W-1:0] len;
            logic [6:0]       bits;
            bit               first;
            bit               bad;
            w = '0;
            if (left != 0) begin
                pos = seq_len - left;
                if (mark_live && ((pos == BOM_POS1 && b != BOM_BYTE1) ||
                                  (pos == BOM_POS2 && b != BOM_BYTE2)))
                    mark_live = 1'b0;
                accum = {accum[CP_W-7:0], b[5:0]};
                left--;
                if (left != 0)
                    return;
                if (mark_live) begin
                    mark_live = 1'b0;
                    n_marks++;
                    return;
                end
                count_char();
                w.code_point = accum;
                queue_word(w);
                return;
            end
            if (b == NUL_BYTE) begin
                w.string_end = 1'b1;
                w.char_count = chars;
                chars        = '0;
                at_start     = 1'b1;
                mark_live    = 1'b0;
                queue_word(w);
                return;
            end
            first     = at_start;
            at_start  = 1'b0;
            mark_live = 1'b0;
            bad       = 1'b0;
            len       = '0;
            bits      = '0;
            casez (b)
                8'b0???????: begin len = 3'd1; bits = b[6:0];          end
                8'b110?????: begin len = 3'd2; bits = {2'b00, b[4:0]};  end
                8'b1110????: begin len = 3'd3; bits = {3'b000, b[3:0]}; end
                8'b11110???: begin len = 3'd4; bits = {4'h0, b[2:0]};   end
                8'b111110??: begin len = 3'd5; bits = {5'h00, b[1:0]};  end
                8'b1111110?: begin len = 3'd6; bits = {6'h00, b[0]};    end
                default:     bad = 1'b1;
            endcase
            if (bad) begin
                accum   = '0;
                seq_len = '0;
                count_char();
                w.bad_lead = 1'b1;
                queue_word(w);
                return;
            end
            accum   = {{(CP_W-7){1'b0}}, bits};
            seq_len = len;
            if (len == 3'd1) begin
                count_char();
                w.code_point = accum;
                queue_word(w);
                return;
            end
            left = len - 3'd1;
            if (first && b == BOM_BYTE0)
                mark_live = 1'b1;
        endfunction

        task report(string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_word(result_t got);
            result_t exp;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word cp=%h end=%b", got.code_point,
                                 got.string_end));
                return;
            end
            exp = expected_words.pop_front();
            n_words++;
            if (exp.string_end) n_ends++;
            if (exp.bad_lead) n_bad++;
            if (exp.string_end && exp.char_count == CNT_MAX) n_capped++;
            if (got.code_point !== exp.code_point)
                report($sformatf("word %0d code_point %h, want %h", n_words,
                                 got.code_point, exp.code_point));
            if (got.bad_lead !== exp.bad_lead)
                report($sformatf("word %0d bad_lead %b, want %b", n_words,
                                 got.bad_lead, exp.bad_lead));
            if (got.string_end !== exp.string_end)
                report($sformatf("word %0d string_end %b, want %b", n_words,
                                 got.string_end, exp.string_end));
            if (got.char_count !== exp.char_count)
                report($sformatf("word %0d char_count %0d, want %0d", n_words,
                                 got.char_count, exp.char_count));
        endtask

        task drain_check();
            if (expected_words.size() != 0)
                report($sformatf("%0d words never arrived", expected_words.size()));
        endtask
    endclass

    decode_scoreboard sb = new();
    logic [7:0]       byte_q[$];
    int               idle_cycles = 0;
    int               bytes_sent  = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side and input side monitors
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
                bytes_sent++;
            end
            if (m_tvalid && m_tready) begin
                got.code_point = m_tdata[30:0];
                got.char_count = m_tdata[46:31];
                got.bad_lead   = m_tuser;
                got.string_end = m_tlast;
                sb.check_word(got);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver stall pattern
    ready_mode_e rx_mode      = READY_ALWAYS;
    int          rx_mode_left = 0;
    int          rx_phase     = 0;

    always @(posedge aclk) begin
        int pick;
        if (rx_mode_left == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 10)      rx_mode = READY_ALWAYS;
            else if (pick < 15) rx_mode = READY_MOSTLY;
            else if (pick < 18) rx_mode = READY_HALF;
            else                rx_mode = READY_SPARSE;
            rx_mode_left = $urandom_range(16, 300);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= ((rx_phase % 8) == 0);
        endcase
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t ns  no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_utf8_stream_decoder_unit: errors");
        $finish;
    end

    task automatic put_byte(logic [7:0] b);
        byte_q = {byte_q, b};
    endtask

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) != 0)
            r[7:6] = 2'b10;
        if ($urandom_range(0, 47) == 0)
            r = NUL_BYTE;
        return r;
    endfunction

    task automatic add_random_char();
        int         pick;
        int         len;
        logic [7:0] r;
        pick = $urandom_range(0, 19);
        r    = 8'($urandom_range(0, 255));
        if (pick < 14) begin
            len = $urandom_range(1, 6);
            case (len)
                1:       put_byte({1'b0, r[6:0]});
                2:       put_byte({3'b110, r[4:0]});
                3:       put_byte({4'b1110, r[3:0]});
                4:       put_byte({5'b11110, r[2:0]});
                5:       put_byte({6'b111110, r[1:0]});
                default: put_byte({7'b1111110, r[0]});
            endcase
            for (int j = 1; j < len; j++)
                put_byte(cont_byte());
        end else if (pick < 17) begin
            if ($urandom_range(0, 5) == 0)
                put_byte({7'h7F, r[0]});
            else
                put_byte({2'b10, r[5:0]});
        end else begin
            put_byte(r);
        end
    endtask

    task automatic add_random_string();
        int n_chars;
        int pick;
        n_chars = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
        pick    = $urandom_range(0, 9);
        if (pick < 3) begin
            put_byte(BOM_BYTE0);
            put_byte(BOM_BYTE1);
            put_byte(BOM_BYTE2);
        end else if (pick == 3) begin
            // mark, possibly damaged
            put_byte(BOM_BYTE0);
            put_byte($urandom_range(0, 1) ? BOM_BYTE1 : cont_byte());
            put_byte($urandom_range(0, 1) ? BOM_BYTE2 : cont_byte());
        end
        for (int i = 0; i < n_chars; i++)
            add_random_char();
        put_byte(NUL_BYTE);
    endtask

    task automatic drive_bytes();
        int burst;
        int gap;
        burst = 0;
        while (byte_q.size() != 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 64);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= byte_q.pop_front();
            do @(posedge aclk); while (!s_tready);
            burst--;
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty string; mark, ascii, bad leads, zero inside a sequence;
        // damaged mark, mark after the first char, largest six byte form
        byte_q = {8'h00,
                  8'hEF, 8'hBB, 8'hBF, 8'h7F, 8'h80, 8'hFE, 8'hFF, 8'hC2, 8'h00, 8'h00,
                  8'hEF, 8'hBB, 8'h80, 8'hEF, 8'hBB, 8'hBF,
                  8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00};
        drive_bytes();

        while (byte_q.size() < RANDOM_BYTES)
            add_random_string();
        drive_bytes();

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        sb.drain_check();

        $display("sent %0d bytes, checked %0d words over %0d strings", bytes_sent,
                 sb.n_words, sb.n_ends);
        $display("bad leads %0d, marks dropped %0d, saturated counts %0d", sb.n_bad,
                 sb.n_marks, sb.n_capped);
        if (sb.errors == 0)
            $display("tb_utf8_stream_decoder_unit: clean");
        else
            $display("tb_utf8_stream_decoder_unit: errors");
        $finish;
    end

endmodule

// ===== utf8_stream_decoder_unit.f =====
sv/u8d_pkg.sv
sv/u8d_lead_dec.sv
sv/u8d_core.sv
sv/utf8_stream_decoder_unit.sv
dv/tb_utf8_stream_decoder_unit.sv
